// File: sv/ivs_pkg.sv
package ivs_pkg;

    localparam int MODE_W = 3;
    localparam int POS_W  = 9;
    localparam int WORD_W = 64;
    localparam int STAT_W = 2;
    localparam int LEN_W  = 9;

    localparam int S_DATA_W = 80;
    localparam int S_USER_W = MODE_W;
    localparam int M_DATA_W = 80;
    localparam int M_USER_W = STAT_W;

    localparam logic [MODE_W-1:0] MODE_SET    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_GET    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ERASE  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PUSH   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_POP    = 3'd5;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd6;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // write address select
    localparam logic [1:0] WA_POS   = 2'd0;
    localparam logic [1:0] WA_COUNT = 2'd1;
    localparam logic [1:0] WA_STEP  = 2'd2;

    // read address select
    localparam logic [1:0] RA_POS   = 2'd0;
    localparam logic [1:0] RA_START = 2'd1;
    localparam logic [1:0] RA_NEXT  = 2'd2;

    // count update
    localparam logic [1:0] CNT_HOLD = 2'd0;
    localparam logic [1:0] CNT_INC  = 2'd1;
    localparam logic [1:0] CNT_DEC  = 2'd2;
    localparam logic [1:0] CNT_CLR  = 2'd3;

    typedef struct packed {
        logic              load_req;
        logic              wr_en;
        logic [1:0]        wr_addr_sel;
        logic              wr_from_rd;
        logic              rd_en;
        logic [1:0]        rd_addr_sel;
        logic              ptr_load;
        logic              ptr_step;
        logic [1:0]        cnt_op;
        logic              stat_load;
        logic [STAT_W-1:0] stat_val;
        logic              word_clr;
        logic              word_cap;
        logic              out_load;
    } ivs_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              pos_lt;
        logic              pos_le;
        logic              full;
        logic              empty;
        logic              no_shift;
        logic              shift_done;
        logic              out_free;
    } ivs_stat_t;

endpackage

// File: sv/ivs_ctrl.sv
module ivs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  ivs_pkg::ivs_stat_t  stat,
    output ivs_pkg::ivs_cmd_t   cmd
);
    import ivs_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;
    localparam logic [2:0] S_RESULT = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign req_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.wr_addr_sel = WA_POS;
        cmd.rd_addr_sel = RA_POS;
        cmd.cnt_op      = CNT_HOLD;
        cmd.stat_val    = ST_OK;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DECODE;
                end
            end

            S_DECODE:
            begin
                cmd.stat_load = 1'b1;
                cmd.word_clr  = 1'b1;
                state_next    = S_RESULT;
                case (stat.mode)
                    MODE_SET:
                    begin
                        if (stat.pos_lt)
                        begin
                            cmd.wr_en = 1'b1;
                        end
                        else
                        begin
                            cmd.stat_val = ST_RANGE;
                        end
                    end
                    MODE_GET:
                    begin
                        if (stat.pos_lt)
                        begin
                            cmd.rd_en  = 1'b1;
                            state_next = S_READ;
                        end
                        else
                        begin
                            cmd.stat_val = ST_RANGE;
                        end
                    end
                    MODE_INSERT:
                    begin
                        if (!stat.pos_le)
                        begin
                            cmd.stat_val = ST_RANGE;
                        end
                        else if (stat.full)
                        begin
                            cmd.stat_val = ST_FULL;
                        end
                        else if (stat.no_shift)
                        begin
                            cmd.wr_en  = 1'b1;
                            cmd.cnt_op = CNT_INC;
                        end
                        else
                        begin
                            cmd.rd_en       = 1'b1;
                            cmd.rd_addr_sel = RA_START;
                            cmd.ptr_load    = 1'b1;
                            state_next      = S_SHIFT;
                        end
                    end
                    MODE_ERASE:
                    begin
                        if (!stat.pos_lt)
                        begin
                            cmd.stat_val = ST_RANGE;
                        end
                        else if (stat.no_shift)
                        begin
                            cmd.cnt_op = CNT_DEC;
                        end
                        else
                        begin
                            cmd.rd_en       = 1'b1;
                            cmd.rd_addr_sel = RA_START;
                            cmd.ptr_load    = 1'b1;
                            state_next      = S_SHIFT;
                        end
                    end
                    MODE_PUSH:
                    begin
                        if (stat.full)
                        begin
                            cmd.stat_val = ST_FULL;
                        end
                        else
                        begin
                            cmd.wr_en       = 1'b1;
                            cmd.wr_addr_sel = WA_COUNT;
                            cmd.cnt_op      = CNT_INC;
                        end
                    end
                    MODE_POP:
                    begin
                        if (stat.empty)
                        begin
                            cmd.stat_val = ST_RANGE;
                        end
                        else
                        begin
                            cmd.cnt_op = CNT_DEC;
                        end
                    end
                    MODE_CLEAR:
                    begin
                        cmd.cnt_op = CNT_CLR;
                    end
                    default:
                    begin
                    end
                endcase
            end

            S_READ:
            begin
                cmd.word_cap = 1'b1;
                state_next   = S_RESULT;
            end

            // one entry moved per cycle; next read overlaps the write
            S_SHIFT:
            begin
                cmd.wr_en       = 1'b1;
                cmd.wr_addr_sel = WA_STEP;
                cmd.wr_from_rd  = 1'b1;
                if (stat.shift_done)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.rd_en       = 1'b1;
                    cmd.rd_addr_sel = RA_NEXT;
                    cmd.ptr_step    = 1'b1;
                end
            end

            S_FINISH:
            begin
                if (stat.mode == MODE_INSERT)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.cnt_op = CNT_INC;
                end
                else
                begin
                    cmd.cnt_op = CNT_DEC;
                end
                state_next = S_RESULT;
            end

            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: sv/ivs_dp.sv
module ivs_dp #(
    parameter int CAPACITY = 256
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ivs_pkg::ivs_cmd_t            cmd,
    output ivs_pkg::ivs_stat_t           stat,
    input  logic [ivs_pkg::MODE_W-1:0]   mode,
    input  logic [ivs_pkg::POS_W-1:0]    position,
    input  logic [ivs_pkg::WORD_W-1:0]   word_in,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ivs_pkg::STAT_W-1:0]   status,
    output logic [ivs_pkg::WORD_W-1:0]   word_out,
    output logic [ivs_pkg::LEN_W-1:0]    length,
    output logic                         is_empty
);
    import ivs_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

    logic [WORD_W-1:0] mem [CAPACITY];

    logic [MODE_W-1:0] mode_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [WORD_W-1:0] word_reg;
    logic [CW-1:0]     cnt_reg;
    logic [CW-1:0]     cnt_next;
    logic [CW-1:0]     ptr_reg;
    logic [WORD_W-1:0] rd_data_reg;
    logic [STAT_W-1:0] stat_res_reg;
    logic [WORD_W-1:0] word_res_reg;
    logic              out_valid_reg;
    logic [STAT_W-1:0] status_reg;
    logic [WORD_W-1:0] word_out_reg;
    logic [LEN_W-1:0]  length_reg;
    logic              is_empty_reg;

    logic [XW-1:0] pos_x;
    logic [XW-1:0] cnt_x;
    logic [XW-1:0] ptr_x;
    logic [XW-1:0] ptr_up;
    logic [XW-1:0] ptr_dn;
    logic [XW-1:0] start_x;
    logic [XW-1:0] wr_addr_x;
    logic [XW-1:0] rd_addr_x;
    logic          is_ins;
    logic [WORD_W-1:0] wr_data;

    assign pos_x   = XW'(pos_reg);
    assign cnt_x   = XW'(cnt_reg);
    assign ptr_x   = XW'(ptr_reg);
    assign ptr_up  = ptr_x + XW'(1);
    assign ptr_dn  = ptr_x - XW'(1);
    assign is_ins  = (mode_reg == MODE_INSERT);
    // insert walks down from the top entry, erase walks up from above the index
    assign start_x = is_ins ? (cnt_x - XW'(1)) : (pos_x + XW'(1));

    assign stat.mode       = mode_reg;
    assign stat.pos_lt     = (pos_x < cnt_x);
    assign stat.pos_le     = (pos_x <= cnt_x);
    assign stat.full       = (cnt_x == XW'(CAPACITY));
    assign stat.empty      = (cnt_reg == '0);
    assign stat.no_shift   = is_ins ? (pos_x == cnt_x) : ((pos_x + XW'(1)) == cnt_x);
    assign stat.shift_done = is_ins ? (ptr_x == pos_x) : (ptr_up == cnt_x);
    assign stat.out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        case (cmd.wr_addr_sel)
            WA_POS:   wr_addr_x = pos_x;
            WA_COUNT: wr_addr_x = cnt_x;
            WA_STEP:  wr_addr_x = is_ins ? ptr_up : ptr_dn;
            default:  wr_addr_x = pos_x;
        endcase
    end

    always_comb
    begin
        case (cmd.rd_addr_sel)
            RA_POS:   rd_addr_x = pos_x;
            RA_START: rd_addr_x = start_x;
            RA_NEXT:  rd_addr_x = is_ins ? ptr_dn : ptr_up;
            default:  rd_addr_x = pos_x;
        endcase
    end

    assign wr_data = cmd.wr_from_rd ? rd_data_reg : word_reg;

    always_comb
    begin
        case (cmd.cnt_op)
            CNT_HOLD: cnt_next = cnt_reg;
            CNT_INC:  cnt_next = cnt_reg + CW'(1);
            CNT_DEC:  cnt_next = cnt_reg - CW'(1);
            CNT_CLR:  cnt_next = '0;
            default:  cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[AW'(wr_addr_x)] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[AW'(rd_addr_x)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            mode_reg <= mode;
            pos_reg  <= position;
            word_reg <= word_in;
        end
        if (cmd.ptr_load)
        begin
            ptr_reg <= CW'(start_x);
        end
        else if (cmd.ptr_step)
        begin
            ptr_reg <= is_ins ? CW'(ptr_dn) : CW'(ptr_up);
        end
        if (cmd.stat_load)
        begin
            stat_res_reg <= cmd.stat_val;
        end
        if (cmd.word_clr)
        begin
            word_res_reg <= '0;
        end
        else if (cmd.word_cap)
        begin
            word_res_reg <= rd_data_reg;
        end
        if (cmd.out_load)
        begin
            status_reg   <= stat_res_reg;
            word_out_reg <= word_res_reg;
            length_reg   <= LEN_W'(cnt_reg);
            is_empty_reg <= (cnt_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign word_out  = word_out_reg;
    assign length    = length_reg;
    assign is_empty  = is_empty_reg;

endmodule

// File: sv/indexed_vector_store.sv
// Flow: a request is accepted in idle and decoded; set, push, pop, clear, rejected requests
// and an insert or erase that moves nothing then go to the result state; get passes a read
// state first; insert and erase that move entries pass the shift state (one memory read and
// one memory write per cycle) and a finish state. A new request is taken the cycle after the
// result is registered, and a result waits while the output register is still held.
// Reset (rst_n low, async) empties the store and handshake state; stored words are kept.
module indexed_vector_store #(
    parameter int CAPACITY = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // position[8:0], word_in[72:9], zero pad
    input  logic [ivs_pkg::S_DATA_W-1:0]    s_tdata,
    // mode[2:0]
    input  logic [ivs_pkg::S_USER_W-1:0]    s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // word_out[63:0], length[72:64], is_empty[73], zero pad
    output logic [ivs_pkg::M_DATA_W-1:0]    m_tdata,
    // status[1:0]
    output logic [ivs_pkg::M_USER_W-1:0]    m_tuser
);
    import ivs_pkg::*;

    ivs_cmd_t          cmd;
    ivs_stat_t         stat;
    logic [STAT_W-1:0] status;
    logic [WORD_W-1:0] word_out;
    logic [LEN_W-1:0]  length;
    logic              is_empty;

    ivs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ivs_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .mode      (s_tuser[MODE_W-1:0]),
        .position  (s_tdata[POS_W-1:0]),
        .word_in   (s_tdata[POS_W+WORD_W-1:POS_W]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .word_out  (word_out),
        .length    (length),
        .is_empty  (is_empty)
    );

    assign m_tdata = {{(M_DATA_W - WORD_W - LEN_W - 1){1'b0}}, is_empty, length, word_out};
    assign m_tuser = status;

endmodule

// File: sv/ivs_checker.sv
module ivs_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [ivs_pkg::M_DATA_W-1:0]    m_tdata,
    input  logic [ivs_pkg::M_USER_W-1:0]    m_tuser
);
    import ivs_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_RANGE || m_tuser == ST_FULL))
        else $error("bad status code");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[WORD_W+LEN_W] == (m_tdata[WORD_W+LEN_W-1:WORD_W] == '0)))
        else $error("empty flag disagrees with length");

    // only a successful get carries a word; checked here as a zero word on failed requests
    a_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != ST_OK |-> m_tdata[WORD_W-1:0] == '0)
        else $error("word on failed request");

endmodule

bind indexed_vector_store ivs_checker u_ivs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
